// ===== rtl/core/lksc_pkg.sv =====
package lksc_pkg;

    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;
    localparam int MODE_W  = 2;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // scan unit control from the sequencer
    typedef struct packed {
        logic start;  // clear trackers, load best stamp bound
        logic dv;     // read data of one entry is on the memory outputs
    } t_scan_ctl;

    // scan unit status back to the sequencer
    typedef struct packed {
        logic match_found;
        logic vic_found;
    } t_scan_flags;

endpackage

// ===== rtl/core/lksc_ram.sv =====
module lksc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lksc_scan.sv =====
module lksc_scan
    import lksc_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_ctl          i_ctl,
    input  logic [AW-1:0]      i_didx,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [STAMP_W-1:0] i_best_init,
    input  logic [KEY_W-1:0]   i_rd_key,
    input  logic [STAMP_W-1:0] i_rd_stamp,
    output t_scan_flags        o_flags,
    output logic [AW-1:0]      o_match_idx,
    output logic [AW-1:0]      o_vic_idx,
    output logic [KEY_W-1:0]   o_vic_key,
    output logic [KEY_W-1:0]   o_key0
);

    t_scan_flags        r_flags;
    logic [AW-1:0]      r_match_idx;
    logic [AW-1:0]      r_vic_idx;
    logic [KEY_W-1:0]   r_vic_key;
    logic [KEY_W-1:0]   r_key0;
    logic [STAMP_W-1:0] r_best;

    logic key_eq;
    logic new_match;
    logic stamp_lt;

    assign key_eq    = (i_rd_key == i_key);
    assign new_match = i_ctl.dv && !r_flags.match_found && key_eq;
    // strict compare while walking downward keeps the highest index on ties
    assign stamp_lt  = i_ctl.dv && (i_rd_stamp < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_ctl.start) begin
            r_flags <= '0;
        end else begin
            if (new_match) begin
                r_flags.match_found <= 1'b1;
            end
            if (stamp_lt) begin
                r_flags.vic_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_best <= i_best_init;
        end else begin
            if (new_match) begin
                r_match_idx <= i_didx;
            end
            if (stamp_lt) begin
                r_best    <= i_rd_stamp;
                r_vic_idx <= i_didx;
                r_vic_key <= i_rd_key;
            end
            if (i_ctl.dv && (i_didx == '0)) begin
                r_key0 <= i_rd_key;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_match_idx = r_match_idx;
    assign o_vic_idx   = r_vic_idx;
    assign o_vic_key   = r_vic_key;
    assign o_key0      = r_key0;

endmodule

// ===== rtl/core/lru_keyed_slot_cache_unit.sv =====
// Fully associative key store with least-recently-used replacement.
// Slave channel: one item per lookup, store or clear; s_tuser carries the
// mode, s_tdata the key and the current time. Master channel: one result
// item per input item; m_tuser carries hit and replaced, m_tdata the slot
// and the evicted key. i_cfg_we/i_cfg_wdata set max_entries.
// Keys and stamps live in two memories with one read port each. A lookup
// or store walks the n valid entries from the top down, one read a cycle;
// with an empty store, and for clear and unused modes, it skips the scan
// and goes straight to the finish state. One item is in work at a time:
// the next is taken the cycle after the result is loaded into the output
// register.
// A result waiting in the output register does not block acceptance, but
// the following result waits for the register to empty when m_tready is low.
// Reset (synchronous, active low) empties the store and sets max_entries
// to 16; memory contents are not cleared and need no clearing pass.
module lru_keyed_slot_cache_unit
    import lksc_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,  // max_entries
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [95:0]      s_tdata,      // key[63:0], time_now[95:64]
    input  logic [1:0]       s_tuser,      // mode[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,      // slot[3:0], evicted_key[67:4], zero[71:68]
    output logic [1:0]       m_tuser       // hit[0], replaced[1]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = ((CW > CFG_W) ? CW : CFG_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_max_entries;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_issue_done, n_issue_done;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_didx, n_didx;
    logic [MODE_W-1:0]   r_mode;
    logic [KEY_W-1:0]    r_key;
    logic [STAMP_W-1:0]  r_now;
    logic                r_m_valid;
    logic [71:0]         r_m_data;
    logic [1:0]          r_m_user;

    logic                accept;
    logic                rd_en;
    logic [KEY_W-1:0]    rd_key;
    logic [STAMP_W-1:0]  rd_stamp;
    t_scan_ctl           scan_ctl;
    t_scan_flags         scan_flags;
    logic [AW-1:0]       match_idx;
    logic [AW-1:0]       vic_idx;
    logic [KEY_W-1:0]    vic_key;
    logic [KEY_W-1:0]    key0;

    logic                fin_go;
    logic                is_scan_mode;
    logic                res_hit;
    logic                do_append;
    logic                do_replace;
    logic                below_lim;
    logic [LW-1:0]       me_ext;
    logic [LW-1:0]       lim;
    logic [AW-1:0]       victim;
    logic [AW-1:0]       widx;
    logic [AW-1:0]       slot_idx;
    logic [AW+3:0]       slot_wide;
    logic [KEY_W-1:0]    evicted;
    logic                key_we;
    logic                stamp_we;
    logic [CW-1:0]       count_m1;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == ST_IDLE);

    // effective limit: max_entries clamped to 1..CAPACITY
    always_comb begin
        me_ext = LW'(r_max_entries);
        if (me_ext == '0) begin
            lim = LW'(1);
        end else if (me_ext > LW'(CAPACITY)) begin
            lim = LW'(CAPACITY);
        end else begin
            lim = me_ext;
        end
    end
    assign below_lim = (LW'(r_count) < lim);

    assign is_scan_mode = (r_mode == MODE_LOOKUP) || (r_mode == MODE_STORE);
    assign res_hit      = is_scan_mode && scan_flags.match_found;
    assign do_append    = (r_mode == MODE_STORE) && !scan_flags.match_found && below_lim;
    assign do_replace   = (r_mode == MODE_STORE) && !scan_flags.match_found && !below_lim;
    // no qualifying stamp falls back to slot 0
    assign victim       = scan_flags.vic_found ? vic_idx : '0;
    assign evicted      = !do_replace ? '0 : (scan_flags.vic_found ? vic_key : key0);

    always_comb begin
        if (res_hit) begin
            widx = match_idx;
        end else if (do_append) begin
            widx = r_count[AW-1:0];
        end else begin
            widx = victim;
        end
    end

    assign slot_idx  = (res_hit || do_append || do_replace) ? widx : '0;
    assign slot_wide = {4'b0000, slot_idx};

    assign fin_go   = (r_state == ST_FINISH) && (!r_m_valid || m_tready);
    assign key_we   = fin_go && (do_append || do_replace);
    assign stamp_we = fin_go && (res_hit || do_append || do_replace);

    assign rd_en          = (r_state == ST_SCAN) && !r_issue_done;
    assign scan_ctl.start = accept;
    assign scan_ctl.dv    = r_dv;

    assign count_m1 = r_count - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_dv         = 1'b0;
        n_didx       = r_didx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (((s_tuser == MODE_LOOKUP) || (s_tuser == MODE_STORE))
                        && (r_count != '0)) begin
                        n_state      = ST_SCAN;
                        n_addr       = count_m1[AW-1:0];
                        n_issue_done = 1'b0;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (!r_issue_done) begin
                    n_dv   = 1'b1;
                    n_didx = r_addr;
                    if (r_addr == '0) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr - AW'(1);
                    end
                end
                // entry 0 is the last one read
                if (r_dv && (r_didx == '0)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                    if (do_append) begin
                        n_count = r_count + CW'(1);
                    end else if (r_mode == MODE_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_max_entries <= MAX_ENTRIES_RST;
            r_count       <= '0;
            r_issue_done  <= 1'b1;
            r_dv          <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_issue_done <= n_issue_done;
            r_dv         <= n_dv;
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
            if (fin_go) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_didx <= n_didx;
        if (accept) begin
            r_mode <= s_tuser;
            r_key  <= s_tdata[63:0];
            r_now  <= s_tdata[95:64];
        end
        if (fin_go) begin
            r_m_data <= {4'b0000, evicted, slot_wide[3:0]};
            r_m_user <= {do_replace, res_hit};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    lksc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (widx),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_key)
    );

    lksc_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (CAPACITY)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (widx),
        .i_wdata (r_now),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_stamp)
    );

    lksc_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_didx      (r_didx),
        .i_key       (r_key),
        .i_best_init (s_tdata[95:64] + STAMP_W'(1)),
        .i_rd_key    (rd_key),
        .i_rd_stamp  (rd_stamp),
        .o_flags     (scan_flags),
        .o_match_idx (match_idx),
        .o_vic_idx   (vic_idx),
        .o_vic_key   (vic_key),
        .o_key0      (key0)
    );

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !(key_we || stamp_we))
        else $error("memory write during scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_hit_xor_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_user[0] && r_m_user[1]))
        else $error("hit and replaced both set");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && do_append) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not advance count");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_dv) |-> (CW'(r_didx) < r_count))
        else $error("scan read beyond entry count");

endmodule

// ===== bench/tb.sv =====
module tb;
    import lksc_pkg::*;

    localparam int CAP = 16;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              replaced;
        logic [KEY_W-1:0]  evicted_key;
    } t_cache_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata = '0;   // key[63:0], time_now[95:64]
    logic [1:0]        s_tuser = '0;   // mode[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [71:0]       m_tdata;        // slot[3:0], evicted_key[67:4], zero[71:68]
    logic [1:0]        m_tuser;        // hit[0], replaced[1]

    lru_keyed_slot_cache_unit #(.CAPACITY(CAP)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // tag store mirror
    logic [KEY_W-1:0]   tag_keys [CAP];
    logic [STAMP_W-1:0] tag_stamps [CAP];
    int                 tag_count = 0;
    logic [CFG_W-1:0]   limit_reg = MAX_ENTRIES_RST;

    t_cache_result pending_results [$];
    int            fail_count = 0;
    int            shown = 0;
    bit            src_idle_en = 1'b1;
    bit            snk_idle_en = 1'b1;
    int            hold_req = 0;
    logic [31:0]   clock_ms = '0;

    function automatic t_cache_result cache_access(input logic [MODE_W-1:0] mode,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [STAMP_W-1:0] now);
        t_cache_result      r;
        int                 found;
        int                 lim;
        int                 victim;
        logic [STAMP_W-1:0] best;
        r = '0;
        found = -1;
        // search top down, first match from the top wins
        for (int i = tag_count - 1; i >= 0; i--)
            if (found < 0 && tag_keys[i] == key)
                found = i;
        lim = (limit_reg == 0) ? 1 : (limit_reg > CAP) ? CAP : int'(limit_reg);
        case (mode)
            MODE_LOOKUP, MODE_STORE: begin
                if (found >= 0) begin
                    tag_stamps[found] = now;
                    r.hit = 1'b1;
                    r.slot = SLOT_W'(found);
                end else if (mode == MODE_STORE && tag_count < lim) begin
                    tag_keys[tag_count] = key;
                    tag_stamps[tag_count] = now;
                    r.slot = SLOT_W'(tag_count);
                    tag_count++;
                end else if (mode == MODE_STORE) begin
                    // oldest stamp below now+1, ties to the highest index, else slot 0
                    victim = 0;
                    best = now + 32'd1;
                    for (int i = tag_count - 1; i >= 0; i--)
                        if (tag_stamps[i] < best) begin
                            victim = i;
                            best = tag_stamps[i];
                        end
                    r.evicted_key = tag_keys[victim];
                    r.replaced = 1'b1;
                    r.slot = SLOT_W'(victim);
                    tag_keys[victim] = key;
                    tag_stamps[victim] = now;
                end
            end
            MODE_CLEAR: tag_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (shown < 10) begin
            shown++;
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result tuser=%h tdata=%h", m_tuser, m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit || m_tuser[1] !== want.replaced ||
                    m_tdata[3:0] !== want.slot || m_tdata[67:4] !== want.evicted_key)
                    note_failure($sformatf(
                        "exp hit=%b slot=%0d repl=%b evict=%h, got hit=%b slot=%0d repl=%b evict=%h",
                        want.hit, want.slot, want.replaced, want.evicted_key,
                        m_tuser[0], m_tdata[3:0], m_tuser[1], m_tdata[67:4]));
            end
        end
    end

    // result receiver: random stall bursts, plus a long hold on request
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                stall_cnt = hold_req;
                hold_req = 0;
            end
            if (stall_cnt > 0) begin
                m_tready <= 1'b0;
                stall_cnt--;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [STAMP_W-1:0] now);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now, key};
        s_tuser <= mode;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(cache_access(mode, key, now));
    endtask

    task automatic wait_drain();
        if (s_tvalid !== 1'b0)
            s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] value);
        wait_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = value;
    endtask

    task automatic run_random_phase(input int n_items, input int pool_size,
                                    input logic [31:0] t_start);
        logic [KEY_W-1:0]  pool [32];
        int                r;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        clock_ms = t_start;
        for (int i = 0; i < pool_size; i++)
            pool[i] = {$urandom(), $urandom()};
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 48)
                mode = MODE_STORE;
            else if (r < 94)
                mode = MODE_LOOKUP;
            else if (r < 97)
                mode = MODE_CLEAR;
            else
                mode = MODE_UNUSED;
            if ($urandom_range(0, 6) == 0)
                key = {$urandom(), $urandom()};
            else
                key = pool[$urandom_range(0, pool_size - 1)];
            // mostly slow time with repeats (equal stamps), now and then a jump
            if ($urandom_range(0, 24) == 0)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, 3);
            send_item(mode, key, clock_ms);
        end
    endtask

    task automatic test_directed();
        send_item(MODE_LOOKUP, '0, 32'd0);
        send_item(MODE_STORE, '0, 32'd0);
        send_item(MODE_STORE, '1, 32'd1);
        send_item(MODE_STORE, 64'h8000_0000_0000_0000, 32'd2);
        send_item(MODE_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 32'd3);
        send_item(MODE_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'd10);
        send_item(MODE_STORE, '0, 32'd11);
        send_item(MODE_LOOKUP, 64'h1234, 32'd12);
        send_item(MODE_UNUSED, '1, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, '1, 32'd13);
        send_item(MODE_LOOKUP, '0, 32'd14);
        // zero limit behaves as one entry
        set_limit(5'd0);
        send_item(MODE_STORE, 64'hA, 32'd5);
        send_item(MODE_STORE, 64'hB, 32'd6);
        send_item(MODE_STORE, 64'hC, 32'hFFFF_FFFF);  // now+1 wraps, slot 0 anyway
        send_item(MODE_STORE, 64'hD, 32'd3);          // nothing older than now+1
        send_item(MODE_CLEAR, '0, 32'd0);
        set_limit(5'd16);
        send_item(MODE_STORE, 64'h11, 32'd100);
        send_item(MODE_STORE, 64'h22, 32'd50);
        send_item(MODE_STORE, 64'h33, 32'd50);
        send_item(MODE_STORE, 64'h44, 32'd200);
        // lowered limit with more entries in use; tie on stamp 50
        set_limit(5'd2);
        send_item(MODE_STORE, 64'h55, 32'd300);
        send_item(MODE_LOOKUP, 64'h55, 32'd301);
    endtask

    task automatic test_random_traffic();
        set_limit(5'd16);
        run_random_phase(90, 20, 32'd1000);
        set_limit(5'd31);
        run_random_phase(90, 24, 32'hFFFF_FF80);
        set_limit(5'd3);   // lowered without a clear
        run_random_phase(90, 6, $urandom());
        set_limit(5'd1);
        run_random_phase(60, 3, $urandom());
        set_limit(5'($urandom_range(2, 15)));
        run_random_phase(90, 16, $urandom());
    endtask

    task automatic test_backpressure();
        set_limit(5'd8);
        src_idle_en = 1'b0;
        hold_req = 300;
        run_random_phase(30, 10, 32'd5000);
        // sender waits for every outstanding result
        wait_drain();
        src_idle_en = 1'b1;
    endtask

    task automatic test_final_burst();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        set_limit(5'd16);
        run_random_phase(80, 22, $urandom());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_backpressure();
        test_final_burst();
        wait_drain();
        repeat (25) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
